>>> rtl/poi_pkg.sv
`timescale 1ns / 1ps
package poi_pkg;
    localparam int TABLE_LEN = 24;
    localparam logic signed [33:0] GAIN_INV_Q30 = 34'sd652032874;

    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0: v = 32'h20000000;
            5'd1: v = 32'h12E4051E;
            5'd2: v = 32'h09FB385B;
            5'd3: v = 32'h051111D4;
            5'd4: v = 32'h028B0D43;
            5'd5: v = 32'h0145D7E1;
            5'd6: v = 32'h00A2F61E;
            5'd7: v = 32'h00517C55;
            5'd8: v = 32'h0028BE53;
            5'd9: v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;
            5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;
            5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction
endpackage

>>> rtl/poi_serial_mul.sv
`timescale 1ns / 1ps
// Signed shift-and-add multiplier: one multiplier bit per cycle.
module poi_serial_mul import poi_pkg::*; #(
    parameter int AW = 34,
    parameter int BW = 34
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [AW-1:0]     i_a,
    input  logic signed [BW-1:0]     i_b,
    output logic                     o_done,
    output logic signed [AW+BW-1:0]  o_prod
);
    localparam int CW = $clog2(BW + 1);
    logic signed [AW+BW-1:0] r_acc, n_acc;
    logic signed [AW+BW-1:0] r_a, n_a;
    logic [BW-1:0] r_b, n_b;
    logic [CW-1:0] r_cnt, n_cnt;
    logic r_busy, n_busy, r_done, n_done;

    always_comb begin
        n_acc = r_acc; n_a = r_a; n_b = r_b; n_cnt = r_cnt;
        n_busy = r_busy; n_done = 1'b0;
        if (i_start) begin
            n_acc = '0;
            n_a = {{BW{i_a[AW-1]}}, i_a};
            n_b = i_b;
            n_cnt = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_b[0]) begin
                if (r_cnt == CW'(BW - 1)) n_acc = r_acc - r_a;
                else n_acc = r_acc + r_a;
            end
            n_a = r_a <<< 1;
            n_b = r_b >> 1;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(BW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_acc <= n_acc; r_a <= n_a; r_b <= n_b; r_cnt <= n_cnt;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

>>> rtl/poi_cordic.sv
`timescale 1ns / 1ps
// Iterative CORDIC, one micro-rotation per cycle, in rotation or vectoring mode.
// The datapath is 36 bits wide so that the vectoring gain on the largest atan2
// operands still fits.
module poi_cordic import poi_pkg::*; #(
    parameter int STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_vector,
    input  logic signed [35:0] i_x,
    input  logic signed [35:0] i_y,
    input  logic signed [35:0] i_z,
    output logic               o_done,
    output logic signed [35:0] o_x,
    output logic signed [35:0] o_y,
    output logic signed [35:0] o_z
);
    localparam int N = (STEPS > TABLE_LEN) ? TABLE_LEN : STEPS;
    logic signed [35:0] r_x, r_y, r_z;
    logic [4:0] r_i;
    logic r_busy, r_done, r_vec;
    logic ccw;
    logic signed [35:0] sx, sy, a;

    assign sx = r_x >>> r_i;
    assign sy = r_y >>> r_i;
    assign a = $signed({4'b0000, atan_entry(r_i)});
    assign ccw = r_vec ? (r_y > 0) : !r_z[35];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_i == 5'(N - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_x <= i_x; r_y <= i_y; r_z <= i_z; r_i <= '0; r_vec <= i_vector;
        end else if (r_busy) begin
            if (ccw) begin
                if (r_vec) begin
                    r_x <= r_x + sy; r_y <= r_y - sx; r_z <= r_z + a;
                end else begin
                    r_x <= r_x - sy; r_y <= r_y + sx; r_z <= r_z - a;
                end
            end else begin
                if (r_vec) begin
                    r_x <= r_x - sy; r_y <= r_y + sx; r_z <= r_z - a;
                end else begin
                    r_x <= r_x + sy; r_y <= r_y - sx; r_z <= r_z + a;
                end
            end
            r_i <= r_i + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule

>>> rtl/planar_odometry_integrator.sv
`timescale 1ns / 1ps
// Planar dead-reckoning integrator. One transaction in gives one transaction
// out. Each item runs sequentially: a CORDIC rotation of the stored heading,
// four serial multiplies for the world velocity, two for the position deltas
// and four for the quaternion terms on one shift-and-add multiplier, and a
// CORDIC vectoring pass for the new heading. Most of an item's time goes to
// the serial multiplier. Steps beyond 24 are not run. When both atan2
// operands are zero the vectoring pass is skipped. The next item is accepted
// once the result register has been loaded; the result waits there until
// taken.
module planar_odometry_integrator import poi_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [23:0] i_body_vel_x,
    input  logic signed [23:0] i_body_vel_y,
    input  logic        [19:0] i_elapsed_time,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    input  logic signed [15:0] i_quat_w,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [15:0] o_heading
);
    localparam logic [4:0] S_IDLE = 5'd0, S_SC = 5'd1, S_SCW = 5'd2,
        S_M1 = 5'd3, S_M2 = 5'd4, S_M3 = 5'd5, S_M4 = 5'd6, S_M5 = 5'd7,
        S_M6 = 5'd8, S_Q1 = 5'd9, S_Q2 = 5'd10, S_Q3 = 5'd11, S_Q4 = 5'd12,
        S_AT = 5'd13, S_ATW = 5'd14, S_OUT = 5'd15;

    logic [4:0] r_st;
    logic signed [23:0] r_vx, r_vy;
    logic [19:0] r_dt;
    logic signed [15:0] r_qx, r_qy, r_qz, r_qw;
    logic signed [31:0] r_accx, r_accy;
    logic signed [15:0] r_head;
    logic signed [33:0] r_c, r_s;
    logic signed [67:0] r_t;
    logic signed [63:0] r_num, r_den;
    logic signed [37:0] r_wx, r_wy;
    logic r_flip, r_busy_mul;

    logic m_start, m_done;
    logic signed [33:0] m_a, m_b;
    logic signed [67:0] m_p;
    logic c_start, c_vec, c_done;
    logic signed [35:0] c_x, c_y, c_z, co_x, co_y, co_z;

    poi_serial_mul #(.AW(34), .BW(34)) u_mul (
        .i_clk, .i_rst_n, .i_start(m_start), .i_a(m_a), .i_b(m_b),
        .o_done(m_done), .o_prod(m_p));

    poi_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk, .i_rst_n, .i_start(c_start), .i_vector(c_vec),
        .i_x(c_x), .i_y(c_y), .i_z(c_z), .o_done(c_done),
        .o_x(co_x), .o_y(co_y), .o_z(co_z));

    // Saturating 32-bit add of a wider delta.
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [67:0] d);
        logic signed [68:0] s;
        s = 69'(a) + 69'(d);
        if (s > 69'sd2147483647) return 32'sh7FFFFFFF;
        if (s < -69'sd2147483648) return 32'sh80000000;
        return s[31:0];
    endfunction

    logic signed [16:0] h_adj;
    logic h_flip;
    assign h_flip = (r_head > 16'sd16384) || (r_head < -16'sd16384);
    assign h_adj = h_flip ? (r_head[15] ? 17'(r_head) + 17'sd32768
                                        : 17'(r_head) - 17'sd32768) : 17'(r_head);

    // The atan2 operands fit in 34 bits signed, but the vectoring gain can
    // carry the magnitude past 2^33, so the CORDIC runs 36 bits wide.
    logic signed [35:0] a_x, a_y;
    logic signed [35:0] a_z;
    logic zero_in;
    assign zero_in = (r_num == 0) && (r_den == 0);
    always_comb begin
        if (r_den < 0) begin
            a_x = -r_den[35:0];
            a_y = -r_num[35:0];
            a_z = {4'b1111, 32'h80000000}; // plus or minus half a turn wraps alike
        end else begin
            a_x = r_den[35:0];
            a_y = r_num[35:0];
            a_z = '0;
        end
    end

    always_comb begin
        m_start = 1'b0; m_a = '0; m_b = '0;
        c_start = 1'b0; c_vec = 1'b0; c_x = '0; c_y = '0; c_z = '0;
        unique case (r_st)
            S_SC: begin
                c_start = 1'b1; c_x = 36'(GAIN_INV_Q30);
                c_z = 36'(h_adj) <<< 16;
            end
            S_M1: begin m_start = !r_busy_mul; m_a = 34'(r_vx); m_b = r_c; end
            S_M2: begin m_start = !r_busy_mul; m_a = 34'(r_vy); m_b = r_s; end
            S_M3: begin m_start = !r_busy_mul; m_a = 34'(r_vx); m_b = r_s; end
            S_M4: begin m_start = !r_busy_mul; m_a = 34'(r_vy); m_b = r_c; end
            S_M5: begin m_start = !r_busy_mul; m_a = 34'(r_wx); m_b = 34'(r_dt); end
            S_M6: begin m_start = !r_busy_mul; m_a = 34'(r_wy); m_b = 34'(r_dt); end
            S_Q1: begin m_start = !r_busy_mul; m_a = 34'(r_qw); m_b = 34'(r_qz); end
            S_Q2: begin m_start = !r_busy_mul; m_a = 34'(r_qx); m_b = 34'(r_qy); end
            S_Q3: begin m_start = !r_busy_mul; m_a = 34'(r_qy); m_b = 34'(r_qy); end
            S_Q4: begin m_start = !r_busy_mul; m_a = 34'(r_qz); m_b = 34'(r_qz); end
            S_AT: begin
                c_start = !zero_in; c_vec = 1'b1; c_x = a_x; c_y = a_y; c_z = a_z;
            end
            default: ;
        endcase
    end

    logic [31:0] z_rnd;
    assign z_rnd = co_z[31:0] + 32'h8000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_accx <= '0; r_accy <= '0; r_head <= '0;
            r_busy_mul <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (r_st == S_OUT && (!o_valid || i_ready)) begin
                o_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            if (m_start) r_busy_mul <= 1'b1;
            unique case (r_st)
                S_IDLE: if (i_valid) begin
                    r_vx <= i_body_vel_x; r_vy <= i_body_vel_y; r_dt <= i_elapsed_time;
                    r_qx <= i_quat_x; r_qy <= i_quat_y; r_qz <= i_quat_z;
                    r_qw <= i_quat_w;
                    r_st <= S_SC;
                end
                S_SC: begin r_flip <= h_flip; r_st <= S_SCW; end
                S_SCW: if (c_done) begin
                    r_c <= 34'(r_flip ? -co_x : co_x);
                    r_s <= 34'(r_flip ? -co_y : co_y);
                    r_st <= S_M1;
                end
                S_M1: if (m_done) begin r_busy_mul <= 1'b0; r_t <= m_p; r_st <= S_M2; end
                S_M2: if (m_done) begin
                    r_busy_mul <= 1'b0;
                    r_wx <= 38'((r_t - m_p + 68'sd536870912) >>> 30);
                    r_st <= S_M3;
                end
                S_M3: if (m_done) begin r_busy_mul <= 1'b0; r_t <= m_p; r_st <= S_M4; end
                S_M4: if (m_done) begin
                    r_busy_mul <= 1'b0;
                    r_wy <= 38'((r_t + m_p + 68'sd536870912) >>> 30);
                    r_st <= S_M5;
                end
                S_M5: if (m_done) begin
                    r_busy_mul <= 1'b0;
                    r_accx <= sat_add(r_accx, (m_p + 68'sd524288) >>> 20);
                    r_st <= S_M6;
                end
                S_M6: if (m_done) begin
                    r_busy_mul <= 1'b0;
                    r_accy <= sat_add(r_accy, (m_p + 68'sd524288) >>> 20);
                    r_st <= S_Q1;
                end
                S_Q1: if (m_done) begin
                    r_busy_mul <= 1'b0; r_num <= 64'(m_p) <<< 1; r_st <= S_Q2;
                end
                S_Q2: if (m_done) begin
                    r_busy_mul <= 1'b0; r_num <= r_num + (64'(m_p) <<< 1);
                    r_den <= 64'sd1073741824; r_st <= S_Q3;
                end
                S_Q3: if (m_done) begin
                    r_busy_mul <= 1'b0; r_den <= r_den - (64'(m_p) <<< 1); r_st <= S_Q4;
                end
                S_Q4: if (m_done) begin
                    r_busy_mul <= 1'b0; r_den <= r_den - (64'(m_p) <<< 1); r_st <= S_AT;
                end
                S_AT: begin
                    if (zero_in) begin
                        r_head <= '0;
                        r_st <= S_OUT;
                    end else begin
                        r_st <= S_ATW;
                    end
                end
                S_ATW: if (c_done) begin
                    r_head <= $signed(z_rnd[31:16]);
                    r_st <= S_OUT;
                end
                S_OUT: if (!o_valid || i_ready) begin
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
        if (r_st == S_OUT && (!o_valid || i_ready)) begin
            o_pos_x <= r_accx; o_pos_y <= r_accy; o_heading <= r_head;
        end
    end

    assign o_ready = (r_st == S_IDLE);
endmodule

>>> rtl/poi_checker.sv
`timescale 1ns / 1ps
module poi_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic signed [31:0] o_pos_x,
    input logic signed [15:0] o_heading
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pos_x) && $stable(o_heading))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("accepted a transaction while busy");
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !o_valid |=> !o_valid)
        else $error("result appeared too early");
endmodule

bind planar_odometry_integrator poi_checker u_poi_checker (
    .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready, .o_pos_x, .o_heading);

>>> bench/tb_planar_odometry_integrator.sv
`timescale 1ns / 1ps
// Self-checking bench for the planar odometry integrator. Every accepted input
// transaction is run through a local fixed-point model of the integrator, and
// the expected position and heading are queued. A monitor compares each output
// transaction, field by field, against the oldest entry in that queue.
module tb_planar_odometry_integrator;
    import poi_pkg::*;

    localparam int STEPS = 16;
    // Roughly the work of one item, rounded up.
    localparam int ITEM_CYCLES = 400;
    localparam int N_RANDOM = 1030;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam longint GAIN_INV = 64'sd652032874;
    localparam longint HALF_TURN = 64'sd2147483648;

    typedef struct packed {
        logic signed [23:0] vel_x;
        logic signed [23:0] vel_y;
        logic        [19:0] dt;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
    } odo_in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
    } pose_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic signed [23:0] i_body_vel_x;
    logic signed [23:0] i_body_vel_y;
    logic        [19:0] i_elapsed_time;
    logic signed [15:0] i_quat_x;
    logic signed [15:0] i_quat_y;
    logic signed [15:0] i_quat_z;
    logic signed [15:0] i_quat_w;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_pos_x;
    logic signed [31:0] o_pos_y;
    logic signed [15:0] o_heading;

    planar_odometry_integrator #(.CORDIC_STEPS(STEPS)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_body_vel_x(i_body_vel_x), .i_body_vel_y(i_body_vel_y),
        .i_elapsed_time(i_elapsed_time),
        .i_quat_x(i_quat_x), .i_quat_y(i_quat_y),
        .i_quat_z(i_quat_z), .i_quat_w(i_quat_w),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_pos_x(o_pos_x), .o_pos_y(o_pos_y), .o_heading(o_heading)
    );

    odo_in_t pending_odo[$];
    pose_t   expected_poses[$];
    longint  model_x, model_y, model_heading;
    int      n_errors;
    bit      stimulus_done;
    longint  cycle_count;
    int      hold_off_cycles;
    bit      hold_off_done;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Arithmetic shift right with floor behaviour, as the hardware does it.
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // CORDIC rotation of the stored heading. Angles beyond a quarter turn are
    // folded by half a turn and the outputs are negated afterwards.
    task automatic heading_sin_cos(input longint ang, output longint c, output longint s);
        bit     folded;
        longint x, y, z, nx;
        folded = 1'b0;
        x = GAIN_INV;
        y = 0;
        if (ang > 16384 || ang < -16384) begin
            folded = 1'b1;
            ang = ang + ((ang > 0) ? -32768 : 32768);
        end
        z = ang * 65536;
        for (int i = 0; i < STEPS && i < TABLE_LEN; i++) begin
            if (z >= 0) begin
                nx = x - shr_floor(y, i);
                y = y + shr_floor(x, i);
                z = z - longint'(atan_entry(5'(i)));
            end else begin
                nx = x + shr_floor(y, i);
                y = y - shr_floor(x, i);
                z = z + longint'(atan_entry(5'(i)));
            end
            x = nx;
        end
        c = folded ? -x : x;
        s = folded ? -y : y;
    endtask

    // CORDIC vectoring over the full circle, rounded to a 16-bit binary angle.
    function automatic longint vector_angle(longint num, longint den);
        longint      x, y, z, nx;
        logic [31:0] a;
        if (num == 0 && den == 0) begin
            return 0;
        end
        x = den;
        y = num;
        z = 0;
        if (den < 0) begin
            x = -den;
            y = -num;
            z = (num >= 0) ? HALF_TURN : -HALF_TURN;
        end
        for (int i = 0; i < STEPS && i < TABLE_LEN; i++) begin
            if (y > 0) begin
                nx = x + shr_floor(y, i);
                y = y - shr_floor(x, i);
                z = z + longint'(atan_entry(5'(i)));
            end else begin
                nx = x - shr_floor(y, i);
                y = y + shr_floor(x, i);
                z = z - longint'(atan_entry(5'(i)));
            end
            x = nx;
        end
        a = z[31:0];
        a = (a + 32'h8000) >> 16;
        return longint'($signed(a[15:0]));
    endfunction

    task automatic integrate_odometry(input odo_in_t t);
        longint c, s, wx, wy, vx, vy, dt, qx, qy, qz, qw, num, den;
        pose_t  p;
        vx = t.vel_x;
        vy = t.vel_y;
        dt = longint'({1'b0, t.dt});
        qx = t.qx;
        qy = t.qy;
        qz = t.qz;
        qw = t.qw;
        heading_sin_cos(model_heading, c, s);
        wx = round_shift(vx * c - vy * s, 30);
        wy = round_shift(vx * s + vy * c, 30);
        model_x = clamp32(model_x + round_shift(wx * dt, 20));
        model_y = clamp32(model_y + round_shift(wy * dt, 20));
        num = 2 * (qw * qz + qx * qy);
        den = (64'sd1 <<< 30) - 2 * (qy * qy + qz * qz);
        model_heading = vector_angle(num, den);
        p.pos_x = model_x[31:0];
        p.pos_y = model_y[31:0];
        p.heading = model_heading[15:0];
        expected_poses.push_back(p);
    endtask

    function automatic odo_in_t make_odo(longint vx, longint vy, longint dt,
                                         longint qx, longint qy, longint qz, longint qw);
        odo_in_t t;
        t.vel_x = vx[23:0];
        t.vel_y = vy[23:0];
        t.dt = dt[19:0];
        t.qx = qx[15:0];
        t.qy = qy[15:0];
        t.qz = qz[15:0];
        t.qw = qw[15:0];
        return t;
    endfunction

    // A yaw-only quaternion for a random heading, so that most items look like
    // a real vehicle turning; the rest are raw noise.
    function automatic odo_in_t random_odo();
        odo_in_t t;
        real     th;
        t = {$urandom, $urandom, $urandom, $urandom, 4'($urandom)};
        if ($urandom_range(0, 3) != 0) begin
            th = ($urandom_range(0, 65535) / 65536.0) * 3.14159265358979;
            t.qx = 16'sd0;
            t.qy = 16'sd0;
            t.qz = 16'($rtoi($sin(th) * 32767.0));
            t.qw = 16'($rtoi($cos(th) * 32767.0));
            if ($urandom_range(0, 1) != 0) begin
                t.qz = -t.qz;
            end
            if ($urandom_range(0, 2) != 0) begin
                t.dt = 20'($urandom_range(0, 20000));
            end
        end
        return t;
    endfunction

    initial begin
        n_errors = 0;
        stimulus_done = 1'b0;
        model_x = 0;
        model_y = 0;
        model_heading = 0;
        // Directed set: field extremes, zero and half-turn headings and an
        // unnormalised quaternion.
        pending_odo.push_back(make_odo(0, 0, 0, 0, 0, 0, 0));
        pending_odo.push_back(make_odo(65536, 0, 1048575, 0, 0, 0, 32767));
        pending_odo.push_back(make_odo(8388607, 8388607, 1048575, 0, 0, 32767, 0));
        pending_odo.push_back(make_odo(-8388608, 8388607, 1048575, 0, 0, -32768, 0));
        pending_odo.push_back(make_odo(-8388608, -8388608, 1048575, 0, 0, 23170, 23170));
        pending_odo.push_back(make_odo(8388607, -8388608, 1048575, -32768, -32768,
                                       -32768, -32768));
        pending_odo.push_back(make_odo(0, 0, 0, 32767, 32767, 32767, 32767));
        pending_odo.push_back(make_odo(0, 0, 0, 23170, 0, 0, -23170));
        pending_odo.push_back(make_odo(0, 0, 0, 0, 32767, 0, 0));
        pending_odo.push_back(make_odo(0, 0, 0, 0, 0, -23170, 23170));
        pending_odo.push_back(make_odo(0, 0, 0, 0, 0, 0, 0));
        // Drive the position far in the positive direction and back.
        for (int k = 0; k < 6; k++) begin
            pending_odo.push_back(make_odo(8388607, 8388607, 1048575, 0, 0, 0, 32767));
        end
        for (int k = 0; k < 6; k++) begin
            pending_odo.push_back(make_odo(-8388608, -8388608, 1048575, 0, 0, 0, 32767));
        end
        pending_odo.push_back(make_odo(1, -1, 1, 0, 0, 1, 0));
        for (int k = 0; k < N_RANDOM; k++) begin
            pending_odo.push_back(random_odo());
        end
        stimulus_done = 1'b1;
    end

    // Sender: bursts of random length separated by random gaps.
    int burst_left;
    int gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                integrate_odometry({i_body_vel_x, i_body_vel_y, i_elapsed_time,
                                    i_quat_x, i_quat_y, i_quat_z, i_quat_w});
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (pending_odo.size() > 0) begin
                {i_body_vel_x, i_body_vel_y, i_elapsed_time,
                 i_quat_x, i_quat_y, i_quat_z, i_quat_w} <= pending_odo.pop_front();
                i_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 900);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: its own stall pattern, plus one long hold-off early in the run
    // so that the block is left full and must stall its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            hold_off_cycles <= 0;
            hold_off_done <= 1'b0;
        end else if (!hold_off_done && expected_poses.size() > 0 && cycle_count > 20000) begin
            hold_off_cycles <= hold_off_cycles + 1;
            i_ready <= 1'b0;
            if (hold_off_cycles >= 5000) begin
                hold_off_done <= 1'b1;
            end
        end else begin
            case (cycle_count[12:11])
                2'd0: i_ready <= 1'b1;
                2'd1: i_ready <= ($urandom_range(0, 3) == 0);
                default: i_ready <= ($urandom_range(0, 1) == 0) ? 1'b1 :
                                    ($urandom_range(0, 600) == 0);
            endcase
        end
    end

    // Monitor: compare each output transaction against the oldest expectation.
    always @(posedge i_clk) begin
        pose_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_poses.size() == 0) begin
                $error("unexpected output transaction pos_x=%0d pos_y=%0d heading=%0d",
                       o_pos_x, o_pos_y, o_heading);
                n_errors++;
            end else begin
                want = expected_poses.pop_front();
                if (o_pos_x !== want.pos_x) begin
                    $error("pos_x expected %0d actual %0d", want.pos_x, o_pos_x);
                    n_errors++;
                end
                if (o_pos_y !== want.pos_y) begin
                    $error("pos_y expected %0d actual %0d", want.pos_y, o_pos_y);
                    n_errors++;
                end
                if (o_heading !== want.heading) begin
                    $error("heading expected %0d actual %0d", want.heading, o_heading);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        cycle_count = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        {i_body_vel_x, i_body_vel_y, i_elapsed_time,
         i_quat_x, i_quat_y, i_quat_z, i_quat_w} = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stimulus_done && pending_odo.size() == 0);
        @(posedge i_clk);
        while (i_valid || expected_poses.size() > 0) begin
            @(posedge i_clk);
        end
        // Allow any stray output to show up before the verdict.
        repeat (ITEM_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
